// ===== src/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string value unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLEAN = 2'd1;
	localparam logic [1:0] KIND_BAD   = 2'd2;

	// results of one request: n decoded bytes, then an optional verdict
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
		logic [1:0]      verdict;
	} rec_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] d;
	} hexd_t;

	function automatic hexd_t hex_digit(input logic [7:0] b);
		hexd_t r;
		r.ok = 1'b1;
		r.d  = 4'd0;
		if (b >= 8'h30 && b <= 8'h39)
			r.d = 4'(b - 8'h30);
		else if (b >= 8'h61 && b <= 8'h66)
			r.d = 4'(b - 8'h57);
		else if (b >= 8'h41 && b <= 8'h46)
			r.d = 4'(b - 8'h37);
		else
			r.ok = 1'b0;
		return r;
	endfunction

	// cp is always <= 0x10FFFF here
	function automatic rec_t utf8_enc(input logic [20:0] cp);
		rec_t r;
		r.bytes   = '0;
		r.verdict = KIND_BYTE;
		if (cp <= 21'h7F) begin
			r.bytes[0] = cp[7:0];
			r.n = 3'd1;
		end else if (cp <= 21'h7FF) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.n = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.n = 3'd3;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.n = 3'd4;
		end
		return r;
	endfunction

endpackage

// ===== src/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Accepts document bytes, runs the decode state machine and pushes one
// result record per request that yields any result.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          start_req,
	input  logic          doc_end,
	input  logic          q_full,
	output logic          push,
	output jsu_pkg::rec_t push_rec
);
	import jsu_pkg::*;

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_WS    = 4'd1;
	localparam logic [3:0] PH_BODY  = 4'd2;
	localparam logic [3:0] PH_ESC   = 4'd3;
	localparam logic [3:0] PH_HEX1  = 4'd4;
	localparam logic [3:0] PH_LOWBS = 4'd5;
	localparam logic [3:0] PH_LOWU  = 4'd6;
	localparam logic [3:0] PH_HEX2  = 4'd7;
	localparam logic [3:0] PH_DONE  = 4'd8;

	logic [3:0]  phase_q, ph, ph_nx;
	logic [15:0] hex_q, hex_c, hex_nx, acc;
	logic [1:0]  cnt_q, cnt_c, cnt_nx;
	logic [9:0]  high_q, high_c, high_nx;
	logic        active;
	hexd_t       hd;
	rec_t        rec;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ph      = start_req ? PH_WS : phase_q;
		hex_c   = start_req ? 16'd0 : hex_q;
		cnt_c   = start_req ? 2'd0 : cnt_q;
		high_c  = start_req ? 10'd0 : high_q;
		ph_nx   = ph;
		hex_nx  = hex_c;
		cnt_nx  = cnt_c;
		high_nx = high_c;
		rec     = '0;
		active  = 1'b1;
		hd      = hex_digit(in_byte);
		acc     = {hex_c[11:0], hd.d};
		case (ph)
			PH_WS: begin
				if ((in_byte >= 8'd9 && in_byte <= 8'd13) || in_byte == 8'd32) begin
				end else if (in_byte == 8'h22) begin
					ph_nx = PH_BODY;
				end else begin
					rec.verdict = KIND_BAD;
				end
			end
			PH_BODY: begin
				if (in_byte == 8'h22) begin
					rec.verdict = KIND_CLEAN;
				end else if (in_byte == 8'h5C) begin
					ph_nx = PH_ESC;
				end else begin
					rec.bytes[0] = in_byte;
					rec.n = 3'd1;
				end
			end
			PH_ESC: begin
				ph_nx = PH_BODY;
				case (in_byte)
					8'h22, 8'h5C, 8'h2F: begin
						rec.bytes[0] = in_byte;
						rec.n = 3'd1;
					end
					8'h62: begin
						rec.bytes[0] = 8'd8;
						rec.n = 3'd1;
					end
					8'h66: begin
						rec.bytes[0] = 8'd12;
						rec.n = 3'd1;
					end
					8'h6E, 8'h72, 8'h74: begin
						rec.bytes[0] = 8'd32;
						rec.n = 3'd1;
					end
					8'h75: begin
						ph_nx  = PH_HEX1;
						hex_nx = 16'd0;
						cnt_nx = 2'd0;
					end
					default: rec.verdict = KIND_BAD;
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				if (!hd.ok) begin
					rec.verdict = KIND_BAD;
				end else begin
					hex_nx = acc;
					if (cnt_c != 2'd3) begin
						cnt_nx = cnt_c + 2'd1;
					end else begin
						cnt_nx = 2'd0;
						if (ph == PH_HEX1) begin
							if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
								high_nx = acc[9:0];
								ph_nx   = PH_LOWBS;
							end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
								rec.verdict = KIND_BAD;
							end else begin
								rec   = utf8_enc({5'd0, acc});
								ph_nx = PH_BODY;
							end
						end else begin
							if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
								rec   = utf8_enc({high_c + 11'h040, acc[9:0]});
								ph_nx = PH_BODY;
							end else begin
								rec.verdict = KIND_BAD;
							end
						end
					end
				end
			end
			PH_LOWBS: begin
				if (in_byte == 8'h5C) ph_nx = PH_LOWU;
				else rec.verdict = KIND_BAD;
			end
			PH_LOWU: begin
				if (in_byte == 8'h75) begin
					ph_nx  = PH_HEX2;
					hex_nx = 16'd0;
					cnt_nx = 2'd0;
				end else begin
					rec.verdict = KIND_BAD;
				end
			end
			default: active = 1'b0;
		endcase
		if (active) begin
			if (rec.verdict == KIND_BYTE && doc_end) begin
				rec.n       = 3'd0;
				rec.bytes   = '0;
				rec.verdict = KIND_BAD;
			end
			if (rec.verdict != KIND_BYTE) ph_nx = PH_DONE;
		end else begin
			rec     = '0;
			ph_nx   = phase_q;
			hex_nx  = hex_q;
			cnt_nx  = cnt_q;
			high_nx = high_q;
		end
	end

	assign push     = accept && (rec.n != 3'd0 || rec.verdict != KIND_BYTE);
	assign push_rec = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q   <= '0;
			cnt_q   <= '0;
			high_q  <= '0;
		end else if (accept) begin
			phase_q <= ph_nx;
			hex_q   <= hex_nx;
			cnt_q   <= cnt_nx;
			high_q  <= high_nx;
		end
	end

endmodule

// ===== src/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Small FIFO of result records between front and back.
// ----------------------------------------------------------------------------
module jsu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::rec_t push_rec,
	input  logic          pop,
	output logic          full,
	output logic          nempty,
	output jsu_pkg::rec_t head
);
	import jsu_pkg::*;

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QDEPTH));
	assign nempty = (cnt_q != '0);
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== src/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Unrolls the head record into result items, one per cycle while the
// output is not held back, through an output register.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          nempty,
	input  jsu_pkg::rec_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic [1:0]    kind,
	output logic          run_end
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       end_q;
	logic       load;
	logic [2:0] total;
	logic       is_last;
	logic       is_byte;

	assign total   = head.n + {2'd0, head.verdict != KIND_BYTE};
	assign is_last = ({1'b0, idx_q} == total - 3'd1);
	assign is_byte = ({1'b0, idx_q} < head.n);
	assign load    = nempty && (!valid_q || out_ready);
	assign pop     = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= is_byte ? head.bytes[idx_q] : 8'd0;
			kind_q <= is_byte ? KIND_BYTE : head.verdict;
			end_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (load) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign kind      = kind_q;
	assign run_end   = end_q;

endmodule

// ===== src/json_string_value_unescape_top.sv =====
// ----------------------------------------------------------------------------
// json_string_value_unescape_top
// JSON string value decoder: whitespace skip, quote check, escape and
// \u surrogate decoding into a UTF-8 result stream.
//
//   channel | dir | tdata            | tuser        | tlast
//   s_*     | in  | in_byte[7:0]     | start_req[0] | doc_end
//   m_*     | out | out_byte[7:0]    | kind[1:0]    | run_end
//
// One input byte per cycle; each yields zero to four results, sent at one
// per cycle from the output register while m_tready is high. Results pass
// through the record queue, then the output register. A four-deep record
// queue decouples the two sides; input stalls while the queue is full, from
// multi-byte results or from output back-pressure.
// Reset clears decode state, queue and output register; no warm-up.
// ----------------------------------------------------------------------------
module json_string_value_unescape_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic [0:0] s_tuser,   // [0] start_req
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast
);
	import jsu_pkg::*;

	logic q_full, q_nempty, push, pop;
	rec_t push_rec, head;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.start_req (s_tuser[0]),
		.doc_end   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_rec  (push_rec)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.full     (q_full),
		.nempty   (q_nempty),
		.head     (head)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nempty    (q_nempty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.kind      (m_tuser),
		.run_end   (m_tlast)
	);

endmodule

// ===== tb/tb_json_string_value_unescape_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_value_unescape_top
// Self-checking bench for the JSON string value unescaper. A short directed
// table is played first: whitespace, quote, extreme bytes, escapes, a
// surrogate pair and the malformed cases. Random values follow, mostly
// well-formed with random content and some broken on purpose. Every accepted
// request is run through a behavioral decoder; every result is checked in
// order against it, or against a directed row's own expected result. Both
// sides idle at random, with one long output hold-off and three full drains.
// ----------------------------------------------------------------------------
module tb_json_string_value_unescape_top;

	import jsu_pkg::*;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CODE_BS   = 8'h08;
	localparam logic [7:0] CODE_FF   = 8'h0C;

	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;

	localparam int RAND_ITEMS = 260;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [3:0] {
		PH_IDLE, PH_WS, PH_BODY, PH_ESC, PH_HEX1, PH_LOWBS, PH_LOWU, PH_HEX2, PH_DONE
	} dec_phase_e;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} out_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       st;
		logic       fin;
		logic       has_exp;
		logic [7:0] xdata;
		logic [1:0] xkind;
	} dir_row_t;

	localparam int N_DIR = 27;
	dir_row_t dir_rows [N_DIR] = '{
		'{8'h41,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{CH_SPACE,  1'b1, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h09,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h0D,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{CH_QUOTE,  1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h00,     1'b0, 1'b0, 1'b1, 8'h00,    KIND_BYTE},
		'{8'hFF,     1'b0, 1'b0, 1'b1, 8'hFF,    KIND_BYTE},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{CH_N,      1'b0, 1'b0, 1'b1, CH_SPACE, KIND_BYTE},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{CH_U,      1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h44,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h38,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h33,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h64,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{CH_U,      1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h64,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h45,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h30,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h30,     1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{CH_QUOTE,  1'b0, 1'b0, 1'b1, 8'h00,    KIND_CLEAN},
		'{8'h71,     1'b1, 1'b0, 1'b1, 8'h00,    KIND_BAD},
		'{CH_QUOTE,  1'b1, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,    KIND_BYTE},
		'{8'h78,     1'b0, 1'b0, 1'b1, 8'h00,    KIND_BAD},
		'{CH_QUOTE,  1'b1, 1'b1, 1'b1, 8'h00,    KIND_BAD}
	};

	logic [7:0] esc_set [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
	logic [7:0] ws_set [6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_SPACE};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic [0:0] s_tuser;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	// decoder state mirror
	dec_phase_e  dec_phase;
	logic [15:0] hex_acc;
	logic [1:0]  hex_cnt;
	logic [9:0]  hi_half;

	out_res_t step_q [$];
	out_res_t expected_out_q [$];

	logic     row_has_exp;
	out_res_t row_exp;
	bit       no_idle;
	int       rx_hold_cycles;
	int       errors;
	int       live_items;
	int       n_checked;
	int       n_clean;
	int       n_bad;
	int       n_values;

	json_string_value_unescape_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bit 4 set when b is a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
		if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h61 + 8'd10)};
		if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h41 + 8'd10)};
		return 5'd0;
	endfunction

	function automatic int utf8_fill(input logic [20:0] cp, output logic [3:0][7:0] o);
		o = '0;
		if (cp <= 21'h7F) begin
			o[0] = cp[7:0];
			return 1;
		end
		if (cp <= 21'h7FF) begin
			o[0] = 8'hC0 | 8'(cp >> 6);
			o[1] = 8'h80 | 8'(cp & 21'h3F);
			return 2;
		end
		if (cp <= 21'hFFFF) begin
			o[0] = 8'hE0 | 8'(cp >> 12);
			o[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
			o[2] = 8'h80 | 8'(cp & 21'h3F);
			return 3;
		end
		o[0] = 8'hF0 | 8'(cp >> 18);
		o[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
		o[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
		o[3] = 8'h80 | 8'(cp & 21'h3F);
		return 4;
	endfunction

	// results of one request go to step_q
	task automatic decode_json_byte(input logic [7:0] b, input logic st, input logic fin);
		logic [3:0][7:0] enc;
		int          n;
		logic        has_verdict;
		logic [1:0]  verdict;
		logic [4:0]  dig;
		logic [20:0] cp;
		int          total;
		out_res_t    r;
		step_q.delete();
		enc = '0;
		n = 0;
		has_verdict = 1'b0;
		verdict = KIND_BAD;
		if (st) begin
			dec_phase = PH_WS;
			hex_acc = '0;
			hex_cnt = '0;
			hi_half = '0;
		end
		case (dec_phase)
			PH_WS: begin
				if ((b >= 8'd9 && b <= 8'd13) || b == CH_SPACE) begin
				end else if (b == CH_QUOTE) begin
					dec_phase = PH_BODY;
				end else begin
					has_verdict = 1'b1;
				end
			end
			PH_BODY: begin
				if (b == CH_QUOTE) begin
					has_verdict = 1'b1;
					verdict = KIND_CLEAN;
				end else if (b == CH_BSLASH) begin
					dec_phase = PH_ESC;
				end else begin
					enc[0] = b;
					n = 1;
				end
			end
			PH_ESC: begin
				dec_phase = PH_BODY;
				n = 1;
				case (b)
					CH_QUOTE, CH_BSLASH, CH_SLASH: enc[0] = b;
					CH_B: enc[0] = CODE_BS;
					CH_F: enc[0] = CODE_FF;
					CH_N, CH_R, CH_T: enc[0] = CH_SPACE;
					CH_U: begin
						n = 0;
						dec_phase = PH_HEX1;
						hex_acc = '0;
						hex_cnt = '0;
					end
					default: begin
						n = 0;
						has_verdict = 1'b1;
					end
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				dig = hex_val(b);
				if (!dig[4]) begin
					has_verdict = 1'b1;
				end else begin
					hex_acc = {hex_acc[11:0], dig[3:0]};
					if (hex_cnt < 2'd3) begin
						hex_cnt = hex_cnt + 2'd1;
					end else begin
						hex_cnt = '0;
						if (dec_phase == PH_HEX1) begin
							if (hex_acc >= HI_SURR_MIN && hex_acc <= HI_SURR_MAX) begin
								hi_half = hex_acc[9:0];
								dec_phase = PH_LOWBS;
							end else if (hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX) begin
								has_verdict = 1'b1;
							end else begin
								n = utf8_fill({5'd0, hex_acc}, enc);
								dec_phase = PH_BODY;
							end
						end else if (hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX) begin
							cp = 21'h10000 + {1'b0, hi_half, 10'd0} + 21'(hex_acc[9:0]);
							n = utf8_fill(cp, enc);
							dec_phase = PH_BODY;
						end else begin
							has_verdict = 1'b1;
						end
					end
				end
			end
			PH_LOWBS: begin
				if (b == CH_BSLASH) dec_phase = PH_LOWU;
				else has_verdict = 1'b1;
			end
			PH_LOWU: begin
				if (b == CH_U) begin
					dec_phase = PH_HEX2;
					hex_acc = '0;
					hex_cnt = '0;
				end else begin
					has_verdict = 1'b1;
				end
			end
			default: return;
		endcase
		// document ended inside the value
		if (!has_verdict && fin) begin
			n = 0;
			has_verdict = 1'b1;
			verdict = KIND_BAD;
		end
		if (has_verdict) dec_phase = PH_DONE;
		total = n + int'(has_verdict);
		for (int k = 0; k < n; k++) begin
			r.data = enc[k];
			r.kind = KIND_BYTE;
			r.last = (k == total - 1);
			step_q = {step_q, r};
		end
		if (has_verdict) begin
			r.data = 8'h00;
			r.kind = verdict;
			r.last = 1'b1;
			step_q = {step_q, r};
		end
	endtask

	// request acceptance and result checking
	always @(posedge clk) begin
		out_res_t exp_r;
		out_res_t got_r;
		if (s_tvalid && s_tready) begin
			if (s_tuser[0] || (dec_phase != PH_IDLE && dec_phase != PH_DONE))
				live_items++;
			decode_json_byte(s_tdata, s_tuser[0], s_tlast);
			if (row_has_exp) expected_out_q = {expected_out_q, row_exp};
			else expected_out_q = {expected_out_q, step_q};
		end
		if (m_tvalid && m_tready) begin
			got_r = '{m_tdata, m_tuser, m_tlast};
			if (expected_out_q.size() == 0) begin
				$display("%0t: unexpected result data %02h kind %0d last %0b",
					$time, got_r.data, got_r.kind, got_r.last);
				errors++;
			end else begin
				exp_r = expected_out_q.pop_front();
				n_checked++;
				if (exp_r.kind == KIND_CLEAN) n_clean++;
				if (exp_r.kind == KIND_BAD) n_bad++;
				if (got_r.data !== exp_r.data || got_r.kind !== exp_r.kind ||
						got_r.last !== exp_r.last) begin
					$display("%0t: mismatch: expected data %02h kind %0d last %0b, got data %02h kind %0d last %0b",
						$time, exp_r.data, exp_r.kind, exp_r.last,
						got_r.data, got_r.kind, got_r.last);
					errors++;
				end
			end
		end
	end

	// output side: random ready gaps, plus an optional long hold-off
	initial begin
		int wait_n;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				m_tready = 1'b0;
				repeat (rx_hold_cycles) @(negedge clk);
				rx_hold_cycles = 0;
			end
			wait_n = no_idle ? 0 : $urandom_range(0, 12);
			if (wait_n > 0) begin
				m_tready = 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic st, input logic fin);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tuser = st;
		s_tlast = fin;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid = 1'b0;
		while (expected_out_q.size() > 0) @(negedge clk);
	endtask

	// \u plus four hex digits of random case
	task automatic push_u(ref logic [7:0] q [$], input logic [15:0] v);
		logic [3:0] nib;
		q = {q, CH_BSLASH};
		q = {q, CH_U};
		for (int i = 3; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			if (nib < 4'd10) q = {q, 8'h30 + 8'(nib)};
			else if ($urandom_range(0, 1)) q = {q, 8'h41 + 8'(nib) - 8'd10};
			else q = {q, 8'h61 + 8'(nib) - 8'd10};
		end
	endtask

	task automatic send_value(input bit broken);
		logic [7:0]  seq [$];
		logic [7:0]  b;
		logic [15:0] cp;
		int          mode;
		int          cut;
		bit          close_last;
		seq = {};
		mode = broken ? $urandom_range(0, 6) : -1;
		repeat ($urandom_range(0, 2)) seq = {seq, ws_set[$urandom_range(0, 5)]};
		seq = {seq, CH_QUOTE};
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
					seq = {seq, b};
				end
				4, 5: begin
					seq = {seq, CH_BSLASH};
					seq = {seq, esc_set[$urandom_range(0, 7)]};
				end
				6, 7: begin
					case ($urandom_range(0, 2))
						0: cp = 16'($urandom_range(0, 16'h7F));
						1: cp = 16'($urandom_range(16'h80, 16'h7FF));
						default: begin
							cp = 16'($urandom_range(16'h800, 16'hFFFF));
							if (cp >= HI_SURR_MIN && cp <= LO_SURR_MAX) cp = cp ^ 16'h4000;
						end
					endcase
					push_u(seq, cp);
				end
				default: begin
					push_u(seq, HI_SURR_MIN | 16'($urandom_range(0, 16'h3FF)));
					push_u(seq, LO_SURR_MIN | 16'($urandom_range(0, 16'h3FF)));
				end
			endcase
		end
		case (mode)
			2: push_u(seq, LO_SURR_MIN | 16'($urandom_range(0, 16'h3FF)));
			3: begin
				push_u(seq, HI_SURR_MIN | 16'($urandom_range(0, 16'h3FF)));
				case ($urandom_range(0, 2))
					0: seq = {seq, 8'h61};
					1: begin
						seq = {seq, CH_BSLASH};
						seq = {seq, CH_N};
					end
					default: push_u(seq, 16'($urandom_range(0, 16'hD7FF)));
				endcase
			end
			4: begin
				seq = {seq, CH_BSLASH};
				seq = {seq, CH_U};
				seq = {seq, 8'h30 + 8'($urandom_range(0, 9))};
				seq = {seq, 8'h67};
			end
			5: begin
				seq = {seq, CH_BSLASH};
				seq = {seq, 8'h78};
			end
			default: ;
		endcase
		seq = {seq, CH_QUOTE};
		if (mode == 0) seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
		cut = (mode == 1 || mode == 6) ? $urandom_range(0, seq.size() - 1) : -1;
		close_last = ($urandom_range(0, 2) == 0);
		for (int pos = 0; pos < seq.size(); pos++) begin
			send_item(seq[pos], pos == 0,
				pos == cut || (pos == seq.size() - 1 && close_last));
			if (pos == cut) break;
		end
		// trailing bytes with no start are ignored once the value has ended
		repeat ($urandom_range(0, 2))
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
		n_values++;
	endtask

	initial begin
		int v;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		row_has_exp = 1'b0;
		row_exp = '0;
		no_idle = 1'b0;
		rx_hold_cycles = 0;
		errors = 0;
		live_items = 0;
		n_checked = 0;
		n_clean = 0;
		n_bad = 0;
		n_values = 0;
		dec_phase = PH_IDLE;
		hex_acc = '0;
		hex_cnt = '0;
		hi_half = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row_has_exp = dir_rows[i].has_exp;
			row_exp = '{dir_rows[i].xdata, dir_rows[i].xkind, 1'b1};
			send_item(dir_rows[i].b, dir_rows[i].st, dir_rows[i].fin);
		end
		row_has_exp = 1'b0;
		drain_results();

		v = 0;
		while (live_items < N_DIR + RAND_ITEMS) begin
			if (v == 4) rx_hold_cycles = HOLD_CYCLES;
			if (v == 9) drain_results();
			no_idle = (v >= 12 && v < 16);
			send_value($urandom_range(0, 3) == 0);
			v++;
		end
		no_idle = 1'b0;
		drain_results();
		repeat (16) @(negedge clk);

		$display("Ran %0d random values plus %0d directed requests, %0d decoding requests.",
			n_values, N_DIR, live_items);
		$display("Checked %0d results: %0d clean closes, %0d malformed.",
			n_checked, n_clean, n_bad);
		if (errors == 0 && expected_out_q.size() == 0) begin
			$display("json_string_value_unescape_top verification clean");
		end else begin
			if (expected_out_q.size() != 0)
				$display("%0t: %0d expected results never arrived", $time, expected_out_q.size());
			$display("json_string_value_unescape_top verification failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("%0t: timeout", $time);
		$display("json_string_value_unescape_top verification failed");
		$finish;
	end

endmodule
